FILE: hdl/matrix_multiply_engine_assert.svh
// Assertion macros shared by the checker files of the matrix multiply engine.
`ifndef MATRIX_MULTIPLY_ENGINE_ASSERT_SVH
`define MATRIX_MULTIPLY_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MME_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MME_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked across reset.
`define MME_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/mme_pkg.sv
// Shared constants, types and helper functions of the matrix multiply engine.
package mme_pkg;

   localparam int MAX_DIM     = 8;
   localparam int VALUE_WIDTH = 16;

   // Fixed field widths of the request and response channels.
   localparam int IDX_BITS    = 3;
   localparam int OUT_BITS    = 16;
   localparam int CFG_BITS    = 4;
   localparam int ACTION_BITS = 2;
   localparam int CSR_IDX_BITS = 2;
   localparam int FRAC_BITS   = 8;
   localparam int DATA_BITS   = 24;

   localparam int STORE_BITS  = (VALUE_WIDTH < OUT_BITS) ? VALUE_WIDTH : OUT_BITS;
   localparam int DIM_BITS    = $clog2(MAX_DIM);
   localparam int DEPTH       = MAX_DIM * MAX_DIM;
   localparam int ADDR_BITS   = $clog2(DEPTH);
   localparam int PROD_BITS   = 2 * STORE_BITS;
   localparam int ACC_BITS    = PROD_BITS + DIM_BITS;

   localparam logic [CFG_BITS-1:0] CFG_RESET = 4'd8;

   localparam logic [ACTION_BITS-1:0] ACT_WR_A = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_WR_B = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_MULT = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] REG_ROWS_A    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_COLS_B    = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                  wr_a;
      logic                  wr_b;
      logic [ADDR_BITS-1:0]  wr_addr;
      logic [STORE_BITS-1:0] wr_data;
      logic                  rd_en;
      logic [ADDR_BITS-1:0]  rd_addr_a;
      logic [ADDR_BITS-1:0]  rd_addr_b;
      logic                  mac_first;
      logic                  mac_last;
      logic                  load_status;
      logic                  status;
      logic                  load_product;
      logic [IDX_BITS-1:0]   out_row;
      logic [IDX_BITS-1:0]   out_col;
      logic                  out_last;
   } mme_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic acc_done;
      logic out_free;
   } mme_status_type;

   // Highest usable index for a raw dimension register; zero acts as one and
   // anything above the maximum acts as the maximum.
   function automatic logic [DIM_BITS-1:0] dim_last(input logic [CFG_BITS-1:0] raw);
      logic [DIM_BITS-1:0] res;
      if (raw == '0) begin
         res = '0;
      end else if (raw > CFG_BITS'(MAX_DIM)) begin
         res = DIM_BITS'(MAX_DIM - 1);
      end else begin
         res = DIM_BITS'(raw - CFG_BITS'(1));
      end
      return res;
   endfunction

   // Column-major element address.
   function automatic logic [ADDR_BITS-1:0] elem_addr(input logic [IDX_BITS-1:0] col,
                                                      input logic [IDX_BITS-1:0] row);
      return ADDR_BITS'(32'(col) * MAX_DIM + 32'(row));
   endfunction

   // Drop the fraction bits (floor) and clamp to the signed element range.
   function automatic logic [OUT_BITS-1:0] saturate(input logic signed [ACC_BITS-1:0] acc);
      logic signed [ACC_BITS-1:0]   q;
      logic signed [ACC_BITS-1:0]   hi;
      logic signed [ACC_BITS-1:0]   lo;
      logic signed [STORE_BITS-1:0] n;
      q  = acc >>> FRAC_BITS;
      hi = {{(ACC_BITS - STORE_BITS + 1){1'b0}}, {(STORE_BITS - 1){1'b1}}};
      lo = ~hi;
      if (q > hi) begin
         n = hi[STORE_BITS-1:0];
      end else if (q < lo) begin
         n = lo[STORE_BITS-1:0];
      end else begin
         n = q[STORE_BITS-1:0];
      end
      return OUT_BITS'(n);
   endfunction

endpackage

FILE: hdl/mme_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mme_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/mme_ctrl.sv
// Controller state machine: decodes requests and sequences the multiply walk.
module mme_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mme_pkg::ACTION_BITS-1:0]     action,
   input  logic [mme_pkg::IDX_BITS-1:0]        row_index,
   input  logic [mme_pkg::IDX_BITS-1:0]        col_index,
   input  logic [mme_pkg::OUT_BITS-1:0]        value,
   input  logic [mme_pkg::DIM_BITS-1:0]        m_last,
   input  logic [mme_pkg::DIM_BITS-1:0]        n_last,
   input  logic [mme_pkg::DIM_BITS-1:0]        p_last,
   input  mme_pkg::mme_status_type             stat,
   output mme_pkg::mme_cmd_type                cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ISSUE = 3'b010,
      ST_WAIT  = 3'b100
   } state_type;

   state_type                     state_ff, state_in;
   logic [mme_pkg::DIM_BITS-1:0]  r_ff, r_in;
   logic [mme_pkg::DIM_BITS-1:0]  c_ff, c_in;
   logic [mme_pkg::DIM_BITS-1:0]  k_ff, k_in;
   logic [mme_pkg::IDX_BITS-1:0]  lim_r, lim_c;
   logic                          bad;
   logic                          is_a;

   assign is_a  = (action == mme_pkg::ACT_WR_A);
   assign lim_r = mme_pkg::IDX_BITS'(is_a ? m_last : n_last);
   assign lim_c = mme_pkg::IDX_BITS'(is_a ? n_last : p_last);
   assign bad   = (row_index > lim_r) || (col_index > lim_c);

   assign req_ready = (state_ff == ST_IDLE) && stat.out_free;

   always_comb begin
      state_in = state_ff;
      r_in     = r_ff;
      c_in     = c_ff;
      k_in     = k_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && stat.out_free) begin
               unique case (action) inside
                  mme_pkg::ACT_WR_A, mme_pkg::ACT_WR_B: begin
                     cmd.wr_a        = is_a && !bad;
                     cmd.wr_b        = !is_a && !bad;
                     cmd.wr_addr     = mme_pkg::elem_addr(col_index, row_index);
                     cmd.wr_data     = value[mme_pkg::STORE_BITS-1:0];
                     cmd.load_status = 1'b1;
                     cmd.status      = bad;
                  end
                  mme_pkg::ACT_MULT: begin
                     r_in     = '0;
                     c_in     = '0;
                     k_in     = '0;
                     state_in = ST_ISSUE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ISSUE: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_addr_a = mme_pkg::elem_addr(mme_pkg::IDX_BITS'(k_ff),
                                               mme_pkg::IDX_BITS'(r_ff));
            cmd.rd_addr_b = mme_pkg::elem_addr(mme_pkg::IDX_BITS'(c_ff),
                                               mme_pkg::IDX_BITS'(k_ff));
            cmd.mac_first = (k_ff == '0);
            cmd.mac_last  = (k_ff == n_last);
            if (k_ff == n_last) begin
               k_in     = '0;
               state_in = ST_WAIT;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_WAIT: begin
            if (stat.acc_done && stat.out_free) begin
               cmd.load_product = 1'b1;
               cmd.out_row      = mme_pkg::IDX_BITS'(r_ff);
               cmd.out_col      = mme_pkg::IDX_BITS'(c_ff);
               cmd.out_last     = (r_ff == m_last) && (c_ff == p_last);
               if (r_ff == m_last) begin
                  r_in = '0;
                  if (c_ff == p_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     c_in     = c_ff + 1'b1;
                     state_in = ST_ISSUE;
                  end
               end else begin
                  r_in     = r_ff + 1'b1;
                  state_in = ST_ISSUE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      r_ff <= r_in;
      c_ff <= c_in;
      k_ff <= k_in;
   end

endmodule

FILE: hdl/mme_datapath.sv
// Datapath: element stores, multiply-accumulate pipeline and result register.
module mme_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  mme_pkg::mme_cmd_type             cmd,
   output mme_pkg::mme_status_type          stat,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic                             out_status,
   output logic [mme_pkg::IDX_BITS-1:0]     out_row,
   output logic [mme_pkg::IDX_BITS-1:0]     out_col,
   output logic [mme_pkg::OUT_BITS-1:0]     out_value,
   output logic                             out_last
);

   logic [mme_pkg::DEPTH-1:0]        valid_a_ff, valid_a_in;
   logic [mme_pkg::DEPTH-1:0]        valid_b_ff, valid_b_in;
   logic                             va_ff, vb_ff;
   logic [mme_pkg::STORE_BITS-1:0]   rd_a, rd_b;
   logic signed [mme_pkg::STORE_BITS-1:0] a_op, b_op;

   logic s1_vld_ff, s1_first_ff, s1_last_ff;
   logic s2_vld_ff, s2_first_ff, s2_last_ff;
   logic signed [mme_pkg::PROD_BITS-1:0] prod_ff, prod_in;
   logic signed [mme_pkg::ACC_BITS-1:0]  acc_ff, acc_in, prod_ext;
   logic                                 acc_done_ff, acc_done_in;

   logic                           out_valid_ff, out_valid_in;
   logic                           out_status_ff, out_status_in;
   logic [mme_pkg::IDX_BITS-1:0]   out_row_ff, out_row_in;
   logic [mme_pkg::IDX_BITS-1:0]   out_col_ff, out_col_in;
   logic [mme_pkg::OUT_BITS-1:0]   out_value_ff, out_value_in;
   logic                           out_last_ff, out_last_in;

   mme_ram #(.WIDTH(mme_pkg::STORE_BITS), .DEPTH(mme_pkg::DEPTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (cmd.wr_a),
      .wr_addr (cmd.wr_addr),
      .wr_data (cmd.wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr_a),
      .rd_data (rd_a)
   );

   mme_ram #(.WIDTH(mme_pkg::STORE_BITS), .DEPTH(mme_pkg::DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (cmd.wr_b),
      .wr_addr (cmd.wr_addr),
      .wr_data (cmd.wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr_b),
      .rd_data (rd_b)
   );

   // Entries never written since reset read as zero.
   always_comb begin
      valid_a_in = valid_a_ff;
      valid_b_in = valid_b_ff;
      if (cmd.wr_a) begin
         valid_a_in[cmd.wr_addr] = 1'b1;
      end
      if (cmd.wr_b) begin
         valid_b_in[cmd.wr_addr] = 1'b1;
      end
   end

   assign a_op     = va_ff ? $signed(rd_a) : '0;
   assign b_op     = vb_ff ? $signed(rd_b) : '0;
   assign prod_in  = a_op * b_op;
   assign prod_ext = mme_pkg::ACC_BITS'(prod_ff);

   always_comb begin
      acc_in      = acc_ff;
      acc_done_in = acc_done_ff && !cmd.load_product;
      if (s2_vld_ff) begin
         acc_in = s2_first_ff ? prod_ext : acc_ff + prod_ext;
         if (s2_last_ff) begin
            acc_done_in = 1'b1;
         end
      end
   end

   assign stat.acc_done = acc_done_ff;
   assign stat.out_free = !out_valid_ff || out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff && !out_ready;
      out_status_in = out_status_ff;
      out_row_in    = out_row_ff;
      out_col_in    = out_col_ff;
      out_value_in  = out_value_ff;
      out_last_in   = out_last_ff;
      if (cmd.load_status) begin
         out_valid_in  = 1'b1;
         out_status_in = cmd.status;
         out_row_in    = '0;
         out_col_in    = '0;
         out_value_in  = '0;
         out_last_in   = 1'b1;
      end else if (cmd.load_product) begin
         out_valid_in  = 1'b1;
         out_status_in = 1'b0;
         out_row_in    = cmd.out_row;
         out_col_in    = cmd.out_col;
         out_value_in  = mme_pkg::saturate(acc_ff);
         out_last_in   = cmd.out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff   <= '0;
         valid_b_ff   <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         acc_done_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_a_ff   <= valid_a_in;
         valid_b_ff   <= valid_b_in;
         s1_vld_ff    <= cmd.rd_en;
         s2_vld_ff    <= s1_vld_ff;
         acc_done_ff  <= acc_done_in;
         out_valid_ff <= out_valid_in;
      end
      if (cmd.rd_en) begin
         va_ff <= valid_a_ff[cmd.rd_addr_a];
         vb_ff <= valid_b_ff[cmd.rd_addr_b];
      end
      s1_first_ff   <= cmd.mac_first;
      s1_last_ff    <= cmd.mac_last;
      s2_first_ff   <= s1_first_ff;
      s2_last_ff    <= s1_last_ff;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      out_status_ff <= out_status_in;
      out_row_ff    <= out_row_in;
      out_col_ff    <= out_col_in;
      out_value_ff  <= out_value_in;
      out_last_ff   <= out_last_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_status = out_status_ff;
   assign out_row    = out_row_ff;
   assign out_col    = out_col_ff;
   assign out_value  = out_value_ff;
   assign out_last   = out_last_ff;

endmodule

FILE: hdl/matrix_multiply_engine.sv
// Top level of the matrix multiply engine: ports, dimension registers, wiring.
//
// The engine holds two 8x8 stores of signed Q8.8 elements, A and B, addressed
// column-major, both reading as zero after reset. Requests arrive on the req_
// stream: tuser carries the action (write A, write B, multiply), tdata carries
// the row, column and value. A write request answers with one response whose
// tuser is the status (1 when the index lies outside the configured shape, in
// which case nothing is stored) and whose tlast is set. A multiply request
// answers with every element of C = A*B in column-major order, tlast on the
// final one. Action three is accepted and dropped.
// Dimensions are set through the csr_ port (index 0 rows of A, 1 inner
// dimension, 2 columns of B; a zero acts as one, values above eight as eight);
// the user must write them only while the engine is idle; the block does not
// enforce this. csr_ready is always high. A write response is shown in the
// cycle after the request is taken. A multiply computes each C element with
// one multiply-accumulate per cycle through a single multiplier. Reset is
// synchronous: the dimensions return to eight and the stores read as zero at
// once. When the response side stalls, the finished response waits in the
// output register and the engine accepts no new request and loads no new
// result until it is taken.
module matrix_multiply_engine (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [mme_pkg::DATA_BITS-1:0]         req_tdata,  // row_index, col_index, value
   input  logic [mme_pkg::ACTION_BITS-1:0]       req_tuser,  // action
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [mme_pkg::DATA_BITS-1:0]         rsp_tdata,  // out_row, out_col, out_value
   output logic                                  rsp_tuser,  // status
   output logic                                  rsp_tlast,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mme_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [mme_pkg::CFG_BITS-1:0]          csr_data
);

   logic [mme_pkg::CFG_BITS-1:0]  rows_a_ff, rows_a_in;
   logic [mme_pkg::CFG_BITS-1:0]  inner_dim_ff, inner_dim_in;
   logic [mme_pkg::CFG_BITS-1:0]  cols_b_ff, cols_b_in;
   logic [mme_pkg::DIM_BITS-1:0]  m_last, n_last, p_last;
   logic [mme_pkg::IDX_BITS-1:0]  row_index, col_index;
   logic [mme_pkg::OUT_BITS-1:0]  value;
   logic [mme_pkg::IDX_BITS-1:0]  out_row, out_col;
   logic [mme_pkg::OUT_BITS-1:0]  out_value;
   mme_pkg::mme_cmd_type          cmd;
   mme_pkg::mme_status_type       stat;

   assign csr_ready = 1'b1;

   // Register writes; an index past the register list is ignored.
   always_comb begin
      rows_a_in    = rows_a_ff;
      inner_dim_in = inner_dim_ff;
      cols_b_in    = cols_b_ff;
      if (csr_valid) begin
         unique case (csr_index)
            mme_pkg::REG_ROWS_A:    rows_a_in    = csr_data;
            mme_pkg::REG_INNER_DIM: inner_dim_in = csr_data;
            mme_pkg::REG_COLS_B:    cols_b_in    = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= mme_pkg::CFG_RESET;
         inner_dim_ff <= mme_pkg::CFG_RESET;
         cols_b_ff    <= mme_pkg::CFG_RESET;
      end else begin
         rows_a_ff    <= rows_a_in;
         inner_dim_ff <= inner_dim_in;
         cols_b_ff    <= cols_b_in;
      end
   end

   assign m_last = mme_pkg::dim_last(rows_a_ff);
   assign n_last = mme_pkg::dim_last(inner_dim_ff);
   assign p_last = mme_pkg::dim_last(cols_b_ff);

   assign row_index = req_tdata[mme_pkg::IDX_BITS-1:0];
   assign col_index = req_tdata[2*mme_pkg::IDX_BITS-1:mme_pkg::IDX_BITS];
   assign value     = req_tdata[2*mme_pkg::IDX_BITS+mme_pkg::OUT_BITS-1:2*mme_pkg::IDX_BITS];

   mme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .action    (req_tuser),
      .row_index (row_index),
      .col_index (col_index),
      .value     (value),
      .m_last    (m_last),
      .n_last    (n_last),
      .p_last    (p_last),
      .stat      (stat),
      .cmd       (cmd)
   );

   mme_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_status (rsp_tuser),
      .out_row    (out_row),
      .out_col    (out_col),
      .out_value  (out_value),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {{(mme_pkg::DATA_BITS - 2*mme_pkg::IDX_BITS - mme_pkg::OUT_BITS){1'b0}},
                       out_value, out_col, out_row};

endmodule

FILE: hdl/mme_checker.sv
// Port-level checker for the matrix multiply engine, bound to the top level.
`include "matrix_multiply_engine_assert.svh"

module mme_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [mme_pkg::DATA_BITS-1:0]       req_tdata,
   input logic [mme_pkg::ACTION_BITS-1:0]     req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [mme_pkg::DATA_BITS-1:0]       rsp_tdata,
   input logic                                rsp_tuser,
   input logic                                rsp_tlast
);

   logic req_unused;

   // The request payload is not inspected beyond the action.
   assign req_unused = ^req_tdata;

   // A stalled response keeps its contents.
   `MME_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled response changed")

   // A rejected write is a single, zero-payload response.
   `MME_ASSERT_IMPLY(a_bad_write, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast && (rsp_tdata == '0), "error response malformed")

   // A taken multiply request starts the walk and blocks new requests.
   `MME_ASSERT_NEXT(a_mult_busy, clock, reset, req_tvalid && req_tready && (req_tuser == mme_pkg::ACT_MULT) && !req_unused | (req_tvalid && req_tready && (req_tuser == mme_pkg::ACT_MULT)), !req_tready, "request taken during multiply")

   // Reset leaves no response pending.
   `MME_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid, "response valid after reset")

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (.*);
